// ----- rtl/obtt_pkg.sv -----
// Shared constants and types for the order book top tracker.
// No dependencies.
package obtt_pkg;

	localparam int LEVELS = 256;                 // entries per side, power of two
	localparam int AW     = $clog2(LEVELS);      // table address width
	localparam int CW     = $clog2(LEVELS + 1);  // count width
	localparam int PW     = 32;                  // price width
	localparam int QW     = 32;                  // size width
	localparam int EW     = PW + QW;             // table entry: price high, size low
	localparam int OW     = 72;                  // result word, padded to bytes

	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_SRD  = 14'b00000000000010,
		S_SCMP = 14'b00000000000100,
		S_UPD  = 14'b00000000001000,
		S_IRD  = 14'b00000000010000,
		S_IWR  = 14'b00000000100000,
		S_DRD  = 14'b00000001000000,
		S_DWR  = 14'b00000010000000,
		S_BRD  = 14'b00000100000000,
		S_BLAT = 14'b00001000000000,
		S_XRD  = 14'b00010000000000,
		S_XCMP = 14'b00100000000000,
		S_XEND = 14'b01000000000000,
		S_ORD  = 14'b10000000000000
	} state_t;

	typedef struct packed {
		logic          re;
		logic [AW-1:0] raddr;
		logic          we;
		logic [AW-1:0] waddr;
		logic [EW-1:0] wdata;
	} ram_ctl_t;

endpackage

// ----- rtl/obtt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module obtt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/order_book_top_tracker.sv -----
// Order book top tracker: sorted bid and ask level tables held in RAM.
// Depends on obtt_pkg and obtt_ram.

// Each side is a sorted table in one RAM, kept as a ring with a head pointer so
// that removing crossed levels from the front is a pointer move. An update scans
// the own side from the best level, then shifts the tail by one level for an
// insert or delete. When the own side is not empty it reads the new best and
// scans the opposite side for crossed levels; then it reads both heads for the
// result. The next input word is taken once the last result has left the
// sequencer, even while that result waits in the output register.
module order_book_top_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // price[31:0], quantity[63:32]
	input  logic        s_tuser,   // kind: 0 bid, 1 ask
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // best_bid[31:0], bid_valid[32], best_ask[64:33],
	                               // ask_valid[65], overflow[66], zero[71:67]
);

	localparam int AW = obtt_pkg::AW;
	localparam int CW = obtt_pkg::CW;
	localparam int PW = obtt_pkg::PW;
	localparam int EW = obtt_pkg::EW;

	obtt_pkg::state_t state_q;
	logic                 kind_q;
	logic [PW-1:0]        price_q;
	logic [obtt_pkg::QW-1:0] qty_q;
	logic [CW-1:0]        cnt_q  [2];
	logic [AW-1:0]        head_q [2];
	logic [CW-1:0]        i_q, j_q, k_q;
	logic                 eq_q, ovf_q;
	logic [PW-1:0]        best_q;
	logic                 out_valid_q;
	logic [obtt_pkg::OW-1:0] out_q;

	obtt_pkg::ram_ctl_t own_ctl, opp_ctl, bid_ctl, ask_ctl;
	logic [EW-1:0] bid_rdata, ask_rdata, own_rdata, opp_rdata;

	logic [CW-1:0] n_own, n_opp, jp1;
	logic [AW-1:0] head_own, head_opp;
	logic [PW-1:0] own_p, opp_p;
	logic          ahead, crossed;
	logic          in_acc, out_free;

	assign n_own    = cnt_q[kind_q];
	assign n_opp    = cnt_q[~kind_q];
	assign head_own = head_q[kind_q];
	assign head_opp = head_q[~kind_q];
	assign jp1      = CW'(j_q + 1'b1);
	assign own_rdata = (kind_q == obtt_pkg::SIDE_ASK) ? ask_rdata : bid_rdata;
	assign opp_rdata = (kind_q == obtt_pkg::SIDE_ASK) ? bid_rdata : ask_rdata;
	assign own_p    = own_rdata[EW-1:EW-PW];
	assign opp_p    = opp_rdata[EW-1:EW-PW];
	assign ahead    = (kind_q == obtt_pkg::SIDE_ASK) ? (own_p < price_q) : (own_p > price_q);
	// opposite level lies strictly beyond the own best
	assign crossed  = (kind_q == obtt_pkg::SIDE_ASK) ? (opp_p > best_q) : (opp_p < best_q);

	assign s_tready = (state_q == obtt_pkg::S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_comb begin
		own_ctl = '0;
		opp_ctl = '0;
		unique case (state_q)
			obtt_pkg::S_SRD: begin
				own_ctl.re    = (i_q != n_own);
				own_ctl.raddr = head_own + i_q[AW-1:0];
			end
			obtt_pkg::S_UPD: begin
				own_ctl.we    = eq_q && (qty_q != '0);
				own_ctl.waddr = head_own + i_q[AW-1:0];
				own_ctl.wdata = {price_q, qty_q};
			end
			obtt_pkg::S_IRD: begin
				own_ctl.re    = (j_q != i_q);
				own_ctl.raddr = head_own + j_q[AW-1:0] - 1'b1;
				own_ctl.we    = (j_q == i_q);
				own_ctl.waddr = head_own + i_q[AW-1:0];
				own_ctl.wdata = {price_q, qty_q};
			end
			obtt_pkg::S_IWR: begin
				own_ctl.we    = 1'b1;
				own_ctl.waddr = head_own + j_q[AW-1:0];
				own_ctl.wdata = own_rdata;
			end
			obtt_pkg::S_DRD: begin
				own_ctl.re    = (jp1 != n_own);
				own_ctl.raddr = head_own + jp1[AW-1:0];
			end
			obtt_pkg::S_DWR: begin
				own_ctl.we    = 1'b1;
				own_ctl.waddr = head_own + j_q[AW-1:0];
				own_ctl.wdata = own_rdata;
			end
			obtt_pkg::S_BRD: begin
				own_ctl.re    = (n_own != '0);
				own_ctl.raddr = head_own;
			end
			obtt_pkg::S_XRD: begin
				opp_ctl.re    = (k_q != n_opp);
				opp_ctl.raddr = head_opp + k_q[AW-1:0];
			end
			obtt_pkg::S_ORD: begin
				own_ctl.re    = 1'b1;
				own_ctl.raddr = head_own;
				opp_ctl.re    = 1'b1;
				opp_ctl.raddr = head_opp;
			end
			default: begin
			end
		endcase
		bid_ctl = (kind_q == obtt_pkg::SIDE_ASK) ? opp_ctl : own_ctl;
		ask_ctl = (kind_q == obtt_pkg::SIDE_ASK) ? own_ctl : opp_ctl;
	end

	obtt_ram #(.WIDTH(EW), .DEPTH(obtt_pkg::LEVELS)) u_bid_ram (
		.clk(clk), .we(bid_ctl.we), .waddr(bid_ctl.waddr), .wdata(bid_ctl.wdata),
		.re(bid_ctl.re), .raddr(bid_ctl.raddr), .rdata(bid_rdata)
	);

	obtt_ram #(.WIDTH(EW), .DEPTH(obtt_pkg::LEVELS)) u_ask_ram (
		.clk(clk), .we(ask_ctl.we), .waddr(ask_ctl.waddr), .wdata(ask_ctl.wdata),
		.re(ask_ctl.re), .raddr(ask_ctl.raddr), .rdata(ask_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= obtt_pkg::S_IDLE;
			cnt_q[0]    <= '0;
			cnt_q[1]    <= '0;
			head_q[0]   <= '0;
			head_q[1]   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				obtt_pkg::S_IDLE: begin
					if (in_acc) begin
						kind_q  <= s_tuser;
						price_q <= s_tdata[31:0];
						qty_q   <= s_tdata[63:32];
						i_q     <= '0;
						k_q     <= '0;
						eq_q    <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= obtt_pkg::S_SRD;
					end
				end
				obtt_pkg::S_SRD: begin
					state_q <= (i_q == n_own) ? obtt_pkg::S_UPD : obtt_pkg::S_SCMP;
				end
				obtt_pkg::S_SCMP: begin
					if (ahead) begin
						i_q     <= CW'(i_q + 1'b1);
						state_q <= obtt_pkg::S_SRD;
					end else begin
						eq_q    <= (own_p == price_q);
						state_q <= obtt_pkg::S_UPD;
					end
				end
				obtt_pkg::S_UPD: begin
					priority if (eq_q && qty_q == '0) begin
						j_q     <= i_q;
						state_q <= obtt_pkg::S_DRD;
					end else if (eq_q || qty_q == '0) begin
						state_q <= obtt_pkg::S_BRD;
					end else if (n_own == CW'(obtt_pkg::LEVELS)) begin
						ovf_q   <= 1'b1;
						state_q <= obtt_pkg::S_BRD;
					end else begin
						j_q     <= n_own;
						state_q <= obtt_pkg::S_IRD;
					end
				end
				obtt_pkg::S_IRD: begin
					if (j_q == i_q) begin
						cnt_q[kind_q] <= CW'(n_own + 1'b1);
						state_q       <= obtt_pkg::S_BRD;
					end else begin
						state_q <= obtt_pkg::S_IWR;
					end
				end
				obtt_pkg::S_IWR: begin
					j_q     <= CW'(j_q - 1'b1);
					state_q <= obtt_pkg::S_IRD;
				end
				obtt_pkg::S_DRD: begin
					if (jp1 == n_own) begin
						cnt_q[kind_q] <= CW'(n_own - 1'b1);
						state_q       <= obtt_pkg::S_BRD;
					end else begin
						state_q <= obtt_pkg::S_DWR;
					end
				end
				obtt_pkg::S_DWR: begin
					j_q     <= jp1;
					state_q <= obtt_pkg::S_DRD;
				end
				obtt_pkg::S_BRD: begin
					state_q <= (n_own == '0) ? obtt_pkg::S_ORD : obtt_pkg::S_BLAT;
				end
				obtt_pkg::S_BLAT: begin
					best_q  <= own_p;
					state_q <= obtt_pkg::S_XRD;
				end
				obtt_pkg::S_XRD: begin
					state_q <= (k_q == n_opp) ? obtt_pkg::S_XEND : obtt_pkg::S_XCMP;
				end
				obtt_pkg::S_XCMP: begin
					if (crossed) begin
						k_q     <= CW'(k_q + 1'b1);
						state_q <= obtt_pkg::S_XRD;
					end else begin
						state_q <= obtt_pkg::S_XEND;
					end
				end
				obtt_pkg::S_XEND: begin
					// crossed levels leave the front by moving the head
					head_q[~kind_q] <= head_opp + k_q[AW-1:0];
					cnt_q[~kind_q]  <= CW'(n_opp - k_q);
					state_q         <= obtt_pkg::S_ORD;
				end
				obtt_pkg::S_ORD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= {5'b0, ovf_q,
							cnt_q[1] != '0, (cnt_q[1] != '0) ? ask_rdata[EW-1:EW-PW] : '0,
							cnt_q[0] != '0, (cnt_q[0] != '0) ? bid_rdata[EW-1:EW-PW] : '0};
						state_q     <= obtt_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= obtt_pkg::S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_bid_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CW'(obtt_pkg::LEVELS)) else $error("bid count over depth");
	a_ask_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[1] <= CW'(obtt_pkg::LEVELS)) else $error("ask count over depth");
	a_not_crossed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[32] && m_tdata[65]) |-> (m_tdata[31:0] <= m_tdata[64:33]))
		else $error("book left crossed");
	a_ovf_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == obtt_pkg::S_BRD && ovf_q) |-> (qty_q != '0 && !eq_q))
		else $error("overflow on non-insert");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == obtt_pkg::S_SCMP) |-> (i_q < n_own)) else $error("scan past count");
`endif

endmodule

// ----- sim/order_book_top_tracker_tb.sv -----
// Testbench for order_book_top_tracker: directed and random book updates,
// checked against an in-bench model of both sorted level tables.
// Depends on obtt_pkg and the block's RTL.
`timescale 1ns / 1ps

module order_book_top_tracker_tb;

	typedef struct packed {
		logic                    side;
		logic [obtt_pkg::PW-1:0] price;
		logic [obtt_pkg::QW-1:0] qty;
	} update_t;

	typedef struct packed {
		logic [obtt_pkg::PW-1:0] best_bid;
		logic                    bid_valid;
		logic [obtt_pkg::PW-1:0] best_ask;
		logic                    ask_valid;
		logic                    overflow;
	} top_t;

	localparam int STALL_LIMIT = 32 * obtt_pkg::LEVELS + 1000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	// input word taken at the last rising edge
	logic        s_tready_seen;

	update_t pending_updates[$];
	top_t    expected_tops[$];
	int      errors;
	int      idle_cycles;
	bit      feed_done;
	int      in_gap;
	int      out_gap;

	// model book: index 0 is the best level on each side
	logic [obtt_pkg::PW-1:0] bid_px[$];
	logic [obtt_pkg::QW-1:0] bid_sz[$];
	logic [obtt_pkg::PW-1:0] ask_px[$];
	logic [obtt_pkg::QW-1:0] ask_sz[$];

	order_book_top_tracker DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// apply one update to a side; returns 1 when a new level was dropped
	function automatic bit book_update(ref logic [obtt_pkg::PW-1:0] px[$],
			ref logic [obtt_pkg::QW-1:0] sz[$], input bit desc,
			input logic [obtt_pkg::PW-1:0] price, input logic [obtt_pkg::QW-1:0] qty);
		int i;
		i = 0;
		while (i < px.size() && (desc ? px[i] > price : px[i] < price)) i++;
		if (i < px.size() && px[i] == price) begin
			if (qty == 0) begin
				px.delete(i);
				sz.delete(i);
			end else
				sz[i] = qty;
			return 1'b0;
		end
		if (qty == 0) return 1'b0;
		if (px.size() >= obtt_pkg::LEVELS) return 1'b1;
		px.insert(i, price);
		sz.insert(i, qty);
		return 1'b0;
	endfunction

	function automatic top_t book_step(update_t u);
		top_t t;
		t = '0;
		if (u.side == obtt_pkg::SIDE_BID) begin
			t.overflow = book_update(bid_px, bid_sz, 1'b1, u.price, u.qty);
			if (bid_px.size() > 0)
				while (ask_px.size() > 0 && ask_px[0] < bid_px[0]) begin
					void'(ask_px.pop_front());
					void'(ask_sz.pop_front());
				end
		end else begin
			t.overflow = book_update(ask_px, ask_sz, 1'b0, u.price, u.qty);
			if (ask_px.size() > 0)
				while (bid_px.size() > 0 && bid_px[0] > ask_px[0]) begin
					void'(bid_px.pop_front());
					void'(bid_sz.pop_front());
				end
		end
		if (bid_px.size() > 0) begin
			t.bid_valid = 1'b1;
			t.best_bid  = bid_px[0];
		end
		if (ask_px.size() > 0) begin
			t.ask_valid = 1'b1;
			t.best_ask  = ask_px[0];
		end
		return t;
	endfunction

	function automatic void add_update(logic side, logic [obtt_pkg::PW-1:0] price,
			logic [obtt_pkg::QW-1:0] qty);
		update_t u;
		u.side  = side;
		u.price = price;
		u.qty   = qty;
		pending_updates.push_back(u);
	endfunction

	function automatic logic [obtt_pkg::QW-1:0] rand_qty();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return '0;
		if (r == 2) return '1;
		return $urandom;
	endfunction

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			in_gap   <= 0;
		end else if (!s_tvalid || s_tready_seen) begin
			if (in_gap > 0) begin
				s_tvalid <= 1'b0;
				in_gap   <= in_gap - 1;
			end else if (pending_updates.size() > 0) begin
				update_t u;
				u = pending_updates.pop_front();
				expected_tops.push_back(book_step(u));
				s_tvalid <= 1'b1;
				s_tdata  <= {u.qty, u.price};
				s_tuser  <= u.side;
				in_gap   <= pick_gap();
			end else
				s_tvalid <= 1'b0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s_tready_seen <= 1'b0;
		else
			s_tready_seen <= s_tvalid && s_tready;
	end

	// output stall pattern
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_gap  <= 0;
		end else if (out_gap > 0) begin
			m_tready <= 1'b0;
			out_gap  <= out_gap - 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (m_tvalid && m_tready) begin
				if (expected_tops.size() == 0) begin
					$error("result word with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					top_t e;
					e = expected_tops.pop_front();
					if (m_tdata[31:0] !== e.best_bid) begin
						$error("best_bid expected %h actual %h", e.best_bid, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[32] !== e.bid_valid) begin
						$error("bid_valid expected %b actual %b", e.bid_valid, m_tdata[32]);
						errors++;
					end
					if (m_tdata[64:33] !== e.best_ask) begin
						$error("best_ask expected %h actual %h", e.best_ask, m_tdata[64:33]);
						errors++;
					end
					if (m_tdata[65] !== e.ask_valid) begin
						$error("ask_valid expected %b actual %b", e.ask_valid, m_tdata[65]);
						errors++;
					end
					if (m_tdata[66] !== e.overflow) begin
						$error("overflow expected %b actual %b", e.overflow, m_tdata[66]);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		logic [obtt_pkg::PW-1:0] mid;
		int                      n;
		errors = 0;
		idle_cycles = 0;
		feed_done = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty sides, deletes of absent levels, extremes, equal prices, crossing
		add_update(obtt_pkg::SIDE_BID, 32'd100, 32'd0);
		add_update(obtt_pkg::SIDE_ASK, 32'd100, 32'd0);
		add_update(obtt_pkg::SIDE_BID, 32'd0, 32'd1);
		add_update(obtt_pkg::SIDE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_update(obtt_pkg::SIDE_BID, 32'd100, 32'd5);
		add_update(obtt_pkg::SIDE_BID, 32'd100, 32'd7);
		add_update(obtt_pkg::SIDE_ASK, 32'd100, 32'd3);
		add_update(obtt_pkg::SIDE_ASK, 32'd110, 32'd3);
		add_update(obtt_pkg::SIDE_ASK, 32'd120, 32'd3);
		add_update(obtt_pkg::SIDE_BID, 32'd115, 32'd9);
		add_update(obtt_pkg::SIDE_ASK, 32'd50, 32'd1);
		add_update(obtt_pkg::SIDE_BID, 32'd40, 32'd0);
		add_update(obtt_pkg::SIDE_ASK, 32'd50, 32'd0);
		add_update(obtt_pkg::SIDE_ASK, 32'hFFFF_FFFF, 32'd0);
		add_update(obtt_pkg::SIDE_BID, 32'hFFFF_FFFF, 32'hAAAA_5555);
		add_update(obtt_pkg::SIDE_ASK, 32'h5555_AAAA, 32'h5555_AAAA);
		add_update(obtt_pkg::SIDE_BID, 32'hFFFF_FFFF, 32'd0);
		add_update(obtt_pkg::SIDE_BID, 32'd0, 32'd0);

		// fill the bid side to capacity, then overflow and overwrite at full
		for (int i = 0; i < obtt_pkg::LEVELS; i++)
			add_update(obtt_pkg::SIDE_BID, 32'd1000 + i, 32'd1 + i);
		add_update(obtt_pkg::SIDE_BID, 32'd10, 32'd4);
		add_update(obtt_pkg::SIDE_BID, 32'd1000, 32'd77);
		add_update(obtt_pkg::SIDE_BID, 32'd5000, 32'd4);
		// crossing ask wipes the full bid side down to one level
		add_update(obtt_pkg::SIDE_ASK, 32'd1000, 32'd2);

		// random: prices mostly near a drifting mid so levels hit, overwrite and cross
		mid = 32'd100000;
		for (int i = 0; i < 420; i++) begin
			logic side;
			logic [obtt_pkg::PW-1:0] p;
			side = $urandom_range(0, 1);
			n = $urandom_range(0, 19);
			if (n == 0) p = $urandom;
			else if (n == 1) p = $urandom_range(0, 1) ? '1 : '0;
			else if (side == obtt_pkg::SIDE_BID) p = mid - $urandom_range(0, 24);
			else p = mid + $urandom_range(0, 24) - 2;
			if ($urandom_range(0, 9) == 0) mid = mid + $urandom_range(0, 8) - 4;
			add_update(side, p, rand_qty());
		end

		wait (pending_updates.size() == 0 && !s_tvalid);
		wait (expected_tops.size() == 0);
		repeat (20) @(posedge clk);
		feed_done = 1'b1;
	end

	initial begin
		wait (arst_n);
		while (!feed_done && idle_cycles < STALL_LIMIT) @(posedge clk);
		if (feed_done) begin
			if (errors == 0 && expected_tops.size() == 0)
				$display("Regression PASS");
			else
				$display("Regression FAIL");
		end else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/obtt_pkg.sv
rtl/obtt_ram.sv
rtl/order_book_top_tracker.sv
sim/order_book_top_tracker_tb.sv
